/* sv/wrs_pkg.sv */
// shared types, codes and defaults for the weighted random selector table
// no dependencies; used by wrs_cell, wrs_scan and the top level
`default_nettype none

package wrs_pkg;

  localparam int DEPTH_DEFAULT       = 16;
  localparam int WEIGHT_BITS_DEFAULT = 16;

  // command codes
  localparam logic [2:0] CMD_ADD      = 3'd0;
  localparam logic [2:0] CMD_REMOVE   = 3'd1;
  localparam logic [2:0] CMD_SET_W    = 3'd2;
  localparam logic [2:0] CMD_CHOOSE   = 3'd3;
  localparam logic [2:0] CMD_READ_W   = 3'd4;
  localparam logic [2:0] CMD_READ_IDX = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NONE    = 2'd1;
  localparam logic [1:0] ST_PRESENT = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // what the scan unit looks for at the head of the ring
  localparam logic [1:0] MATCH_ID  = 2'd0;
  localparam logic [1:0] MATCH_POS = 2'd1;
  localparam logic [1:0] MATCH_CUM = 2'd2;

  typedef struct packed {
    logic rotate;
    logic shift_down;
    logic write_id;
    logic write_weight;
  } cell_ctrl_t;

  typedef struct packed {
    logic       clear;
    logic       step;
    logic       mul;
    logic [1:0] mode;
  } scan_ctrl_t;

endpackage

`default_nettype wire

/* sv/wrs_cell.sv */
// one table cell: holds an id and a weight, takes its neighbour's entry
// on rotate or on shift-down at or above sel_idx, or a written value; uses wrs_pkg
`default_nettype none

module wrs_cell #(
  parameter int DEPTH       = wrs_pkg::DEPTH_DEFAULT,
  parameter int WEIGHT_BITS = wrs_pkg::WEIGHT_BITS_DEFAULT,
  parameter int INDEX       = 0
) (
  input  wire logic                     clk,
  input  wire wrs_pkg::cell_ctrl_t      ctrl,
  input  wire logic [$clog2(DEPTH)-1:0] sel_idx,
  input  wire logic [31:0]              nb_id,
  input  wire logic [WEIGHT_BITS-1:0]   nb_weight,
  input  wire logic [31:0]              wr_id,
  input  wire logic [WEIGHT_BITS-1:0]   wr_weight,
  output logic      [31:0]              id,
  output logic      [WEIGHT_BITS-1:0]   weight
);

  localparam int IW = $clog2(DEPTH);
  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

  logic take_nb;
  logic is_sel;

  assign take_nb = ctrl.rotate || (ctrl.shift_down && (MY_IDX >= sel_idx));
  assign is_sel  = (MY_IDX == sel_idx);

  always_ff @(posedge clk) begin
    if (take_nb) begin
      id     <= nb_id;
      weight <= nb_weight;
    end else begin
      if (ctrl.write_id && is_sel) begin
        id <= wr_id;
      end
      if (ctrl.write_weight && is_sel) begin
        weight <= wr_weight;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/wrs_scan.sv */
// head scanner: examines the entry at the front of the ring each cycle that step is set,
// finds by id or position, sums weights and picks by cumulative weight; uses wrs_pkg
`default_nettype none

module wrs_scan #(
  parameter int DEPTH       = wrs_pkg::DEPTH_DEFAULT,
  parameter int WEIGHT_BITS = wrs_pkg::WEIGHT_BITS_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire wrs_pkg::scan_ctrl_t        ctrl,
  input  wire logic [31:0]                head_id,
  input  wire logic [WEIGHT_BITS-1:0]     head_weight,
  input  wire logic [$clog2(DEPTH+1)-1:0] pos,
  input  wire logic [$clog2(DEPTH+1)-1:0] count,
  input  wire logic [31:0]                key,
  input  wire logic [3:0]                 idx,
  input  wire logic [15:0]                frac,
  output logic                            found,
  output logic [$clog2(DEPTH)-1:0]        slot,
  output logic [31:0]                     pick_id,
  output logic [WEIGHT_BITS-1:0]          pick_weight,
  output logic                            total_nz
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);
  localparam int SW = WEIGHT_BITS + $clog2(DEPTH);
  localparam int TW = SW + 16;

  logic [SW-1:0] sum;
  logic [SW-1:0] cum_next;
  logic [TW-1:0] target;
  logic [TW-1:0] prod;
  logic          in_range;
  logic          match;
  logic          take;

  assign in_range = pos < count;
  assign cum_next = sum + SW'(head_weight);
  assign prod     = {{SW{1'b0}}, frac} * {16'b0, sum};

  always_comb begin
    unique case (ctrl.mode)
      wrs_pkg::MATCH_ID:  match = (head_id == key);
      wrs_pkg::MATCH_POS: match = ({{CW{1'b0}}, idx} == {4'b0, pos});
      wrs_pkg::MATCH_CUM: match = ({cum_next, 16'b0} >= target);
      default:            match = 1'b0;
    endcase
  end

  assign take = ctrl.step && in_range && match && !found;

  always_ff @(posedge clk) begin
    if (rst) begin
      found    <= 1'b0;
      total_nz <= 1'b0;
    end else begin
      if (ctrl.clear) begin
        found <= 1'b0;
      end else if (take) begin
        found <= 1'b1;
      end
      if (ctrl.mul) begin
        total_nz <= (sum != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      sum <= '0;
    end else if (ctrl.step && in_range) begin
      sum <= cum_next;
    end
    if (take) begin
      slot        <= pos[IW-1:0];
      pick_id     <= head_id;
      pick_weight <= head_weight;
    end
    // target = r * total, taken while sum still holds the total
    if (ctrl.mul) begin
      target <= prod;
    end
  end

endmodule

`default_nettype wire

/* sv/weighted_random_selector_table.sv */
// weighted random selector table: a ring of DEPTH cells rotated past one scanner
// each pass rotates the whole ring once; an accepted command makes one pass, then applies;
// choose adds a multiply state and a pick pass between the two
// one command at a time: a new one is accepted only in idle; out stalls hold the apply state
// reset: count cleared, output empty; cells and result ports undefined until written
`default_nettype none

module weighted_random_selector_table #(
  parameter int DEPTH       = wrs_pkg::DEPTH_DEFAULT,
  parameter int WEIGHT_BITS = wrs_pkg::WEIGHT_BITS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  command,
  input  wire logic [31:0] entry_id,
  input  wire logic [15:0] weight,
  input  wire logic [15:0] random_fraction,
  input  wire logic [3:0]  slot_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [31:0]      result_id,
  output logic [15:0]      result_weight,
  output logic [4:0]       entry_count
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PASS1 = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_PASS2 = 3'd3;
  localparam logic [2:0] S_APPLY = 3'd4;

  logic [2:0]             state;
  logic [CW-1:0]          pos;
  logic [CW-1:0]          count;
  logic [CW-1:0]          count_next;
  logic [2:0]             cmd_q;
  logic [31:0]            key_q;
  logic [WEIGHT_BITS-1:0] w_q;
  logic [15:0]            frac_q;
  logic [3:0]             idx_q;

  logic                   accept;
  logic                   can_load;
  logic                   pass_end;
  logic [31:0]            w_ext;
  logic [31:0]            pw_ext;

  logic [1:0]             st_n;
  logic [31:0]            rid_n;
  logic [15:0]            rw_n;

  wrs_pkg::cell_ctrl_t    cell_ctrl;
  wrs_pkg::scan_ctrl_t    scan_ctrl;
  logic [IW-1:0]          sel_idx;

  logic [31:0]            cell_id [DEPTH];
  logic [WEIGHT_BITS-1:0] cell_w  [DEPTH];

  logic                   found;
  logic [IW-1:0]          slot;
  logic [31:0]            pick_id;
  logic [WEIGHT_BITS-1:0] pick_weight;
  logic                   total_nz;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign can_load = !out_valid || out_ready;
  assign pass_end = (pos == CW'(DEPTH-1));
  assign w_ext    = {16'b0, weight};
  assign pw_ext   = 32'(pick_weight);

  // ring of cells, cell 0 is the head seen by the scanner
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    wrs_cell #(
      .DEPTH       (DEPTH),
      .WEIGHT_BITS (WEIGHT_BITS),
      .INDEX       (i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .sel_idx   (sel_idx),
      .nb_id     (cell_id[(i+1) % DEPTH]),
      .nb_weight (cell_w[(i+1) % DEPTH]),
      .wr_id     (key_q),
      .wr_weight (w_q),
      .id        (cell_id[i]),
      .weight    (cell_w[i])
    );
  end

  wrs_scan #(
    .DEPTH       (DEPTH),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (scan_ctrl),
    .head_id     (cell_id[0]),
    .head_weight (cell_w[0]),
    .pos         (pos),
    .count       (count),
    .key         (key_q),
    .idx         (idx_q),
    .frac        (frac_q),
    .found       (found),
    .slot        (slot),
    .pick_id     (pick_id),
    .pick_weight (pick_weight),
    .total_nz    (total_nz)
  );

  always_comb begin
    scan_ctrl.clear = accept || (state == S_MUL);
    scan_ctrl.mul   = (state == S_MUL);
    scan_ctrl.step  = (state == S_PASS1) || (state == S_PASS2);
    if (state == S_PASS2) begin
      scan_ctrl.mode = wrs_pkg::MATCH_CUM;
    end else if (cmd_q == wrs_pkg::CMD_READ_IDX) begin
      scan_ctrl.mode = wrs_pkg::MATCH_POS;
    end else begin
      scan_ctrl.mode = wrs_pkg::MATCH_ID;
    end

    cell_ctrl.rotate       = scan_ctrl.step;
    cell_ctrl.shift_down   = 1'b0;
    cell_ctrl.write_id     = 1'b0;
    cell_ctrl.write_weight = 1'b0;
    sel_idx                = slot;

    st_n       = wrs_pkg::ST_NONE;
    rid_n      = '0;
    rw_n       = '0;
    count_next = count;

    if ((state == S_APPLY) && can_load) begin
      unique case (cmd_q)
        wrs_pkg::CMD_ADD: begin
          if (found) begin
            st_n = wrs_pkg::ST_PRESENT;
          end else if (count == CW'(DEPTH)) begin
            st_n = wrs_pkg::ST_FULL;
          end else begin
            st_n                   = wrs_pkg::ST_OK;
            sel_idx                = count[IW-1:0];
            cell_ctrl.write_id     = 1'b1;
            cell_ctrl.write_weight = 1'b1;
            count_next             = count + CW'(1);
          end
        end
        wrs_pkg::CMD_REMOVE: begin
          if (found) begin
            st_n                 = wrs_pkg::ST_OK;
            cell_ctrl.shift_down = 1'b1;
            count_next           = count - CW'(1);
          end
        end
        wrs_pkg::CMD_SET_W: begin
          if (found) begin
            st_n                   = wrs_pkg::ST_OK;
            cell_ctrl.write_weight = 1'b1;
          end
        end
        wrs_pkg::CMD_CHOOSE: begin
          if (found && total_nz) begin
            st_n  = wrs_pkg::ST_OK;
            rid_n = pick_id;
          end
        end
        wrs_pkg::CMD_READ_W: begin
          if (found) begin
            st_n = wrs_pkg::ST_OK;
            rw_n = pw_ext[15:0];
          end
        end
        wrs_pkg::CMD_READ_IDX: begin
          if (found) begin
            st_n  = wrs_pkg::ST_OK;
            rid_n = pick_id;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pos       <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            pos   <= '0;
            state <= S_PASS1;
          end
        end
        S_PASS1: begin
          if (pass_end) begin
            pos   <= '0;
            state <= (cmd_q == wrs_pkg::CMD_CHOOSE) ? S_MUL : S_APPLY;
          end else begin
            pos <= pos + CW'(1);
          end
        end
        S_MUL: begin
          state <= S_PASS2;
        end
        S_PASS2: begin
          if (pass_end) begin
            pos   <= '0;
            state <= S_APPLY;
          end else begin
            pos <= pos + CW'(1);
          end
        end
        S_APPLY: begin
          if (can_load) begin
            out_valid <= 1'b1;
            count     <= count_next;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // transaction payload and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= command;
      key_q  <= entry_id;
      w_q    <= w_ext[WEIGHT_BITS-1:0];
      frac_q <= random_fraction;
      idx_q  <= slot_index;
    end
    if ((state == S_APPLY) && can_load) begin
      status        <= st_n;
      result_id     <= rid_n;
      result_weight <= rw_n;
      entry_count   <= 5'(count_next);
    end
  end

endmodule

`default_nettype wire
